// File: src/fqmm_pkg.sv
// ----------------------------------------------------------------------------
// fqmm_pkg
// Types and constants shared by the FIFO queue with min/max search unit.
// ----------------------------------------------------------------------------
package fqmm_pkg;

    localparam int ID_W    = 32;
    localparam int SCORE_W = 16;
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;
    localparam int REC_W   = ID_W + SCORE_W;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_MAX = 2'd2,
        OP_MIN = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_SCAN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic en;
        logic first;
        logic find_max;
    } t_best_ctl;

endpackage

// File: src/fqmm_ram.sv
// ----------------------------------------------------------------------------
// fqmm_ram
// Record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fqmm_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int W     = 48
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/fqmm_best.sv
// ----------------------------------------------------------------------------
// fqmm_best
// Shared signed score comparator holding the current best record of a scan.
// ----------------------------------------------------------------------------
module fqmm_best (
    input  logic                                 i_clk,
    input  fqmm_pkg::t_best_ctl                  i_ctl,
    input  logic        [fqmm_pkg::ID_W-1:0]     i_id,
    input  logic signed [fqmm_pkg::SCORE_W-1:0]  i_score,
    output logic        [fqmm_pkg::ID_W-1:0]     o_best_id,
    output logic signed [fqmm_pkg::SCORE_W-1:0]  o_best_score
);

    logic        [fqmm_pkg::ID_W-1:0]    r_best_id;
    logic signed [fqmm_pkg::SCORE_W-1:0] r_best_score;
    logic                                take;

    always_comb begin
        if (i_ctl.first) begin
            take = 1'b1;
        end else if (i_ctl.find_max) begin
            take = (i_score > r_best_score);
        end else begin
            take = (i_score < r_best_score);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en && take) begin
            r_best_id    <= i_id;
            r_best_score <= i_score;
        end
    end

    assign o_best_id    = r_best_id;
    assign o_best_score = r_best_score;

endmodule

// File: src/fifo_queue_min_max_search_unit.sv
// ----------------------------------------------------------------------------
// fifo_queue_min_max_search_unit
// FIFO of (id, score) records in a ring with largest/smallest score search.
// ----------------------------------------------------------------------------
// One operation per input beat, one result beat per operation. Enqueue and
// any rejected operation (full or empty) are settled in the accept cycle;
// dequeue returns the head entry from S_DEQ; a search walks every entry in
// S_SCAN, then S_FIN, as the single read port of the record store delivers
// one entry per cycle to the shared comparator. The next beat is taken in
// S_IDLE once the result register is free or drains in the same cycle.
module fifo_queue_min_max_search_unit #(
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic        [fqmm_pkg::OP_W-1:0]     i_operation,
    input  logic        [fqmm_pkg::ID_W-1:0]     i_record_id,
    input  logic signed [fqmm_pkg::SCORE_W-1:0]  i_record_score,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic        [fqmm_pkg::ST_W-1:0]     o_status,
    output logic        [fqmm_pkg::ID_W-1:0]     o_found_id,
    output logic signed [fqmm_pkg::SCORE_W-1:0]  o_found_score,
    output logic        [$clog2(DEPTH+1)-1:0]    o_entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    fqmm_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_left, n_left;
    logic          r_first, n_first;
    logic          r_find_max, n_find_max;

    logic                                r_out_valid, n_out_valid;
    logic [fqmm_pkg::ST_W-1:0]           r_status, n_status;
    logic [fqmm_pkg::ID_W-1:0]           r_id, n_id;
    logic signed [fqmm_pkg::SCORE_W-1:0] r_score, n_score;
    logic [CW-1:0]                       r_cnt_out, n_cnt_out;

    logic                                ram_we;
    logic                                ram_re;
    logic [AW-1:0]                       ram_raddr;
    logic [fqmm_pkg::REC_W-1:0]          ram_rdata;
    logic [fqmm_pkg::ID_W-1:0]           rd_id;
    logic signed [fqmm_pkg::SCORE_W-1:0] rd_score;
    fqmm_pkg::t_best_ctl                 best_ctl;
    logic [fqmm_pkg::ID_W-1:0]           best_id;
    logic signed [fqmm_pkg::SCORE_W-1:0] best_score;
    logic                                in_ready;
    logic                                in_take;
    fqmm_pkg::t_op                       op;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        ring_next = (p == LAST_PTR) ? '0 : p + AW'(1);
    endfunction

    assign rd_id    = ram_rdata[fqmm_pkg::REC_W-1:fqmm_pkg::SCORE_W];
    assign rd_score = ram_rdata[fqmm_pkg::SCORE_W-1:0];
    assign op       = fqmm_pkg::t_op'(i_operation);

    assign in_ready   = (r_state == fqmm_pkg::S_IDLE) && (!r_out_valid || !i_out_stall);
    assign in_take    = i_in_valid && in_ready;
    assign o_in_stall = !in_ready;

    fqmm_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .W     (fqmm_pkg::REC_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata ({i_record_id, i_record_score}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fqmm_best u_best (
        .i_clk        (i_clk),
        .i_ctl        (best_ctl),
        .i_id         (rd_id),
        .i_score      (rd_score),
        .o_best_id    (best_id),
        .o_best_score (best_score)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fqmm_pkg::S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr   <= n_rd_ptr;
        r_left     <= n_left;
        r_first    <= n_first;
        r_find_max <= n_find_max;
        r_status   <= n_status;
        r_id       <= n_id;
        r_score    <= n_score;
        r_cnt_out  <= n_cnt_out;
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_rd_ptr    = r_rd_ptr;
        n_left      = r_left;
        n_first     = r_first;
        n_find_max  = r_find_max;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_id        = r_id;
        n_score     = r_score;
        n_cnt_out   = r_cnt_out;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = r_rd_ptr;
        best_ctl    = '0;

        unique case (r_state)
            fqmm_pkg::S_IDLE: begin
                if (in_take) begin
                    n_id    = '0;
                    n_score = '0;
                    if (op == fqmm_pkg::OP_ENQ) begin
                        n_out_valid = 1'b1;
                        if (r_count == FULL_CNT) begin
                            n_status  = fqmm_pkg::ST_FULL;
                            n_cnt_out = r_count;
                        end else begin
                            ram_we    = 1'b1;
                            n_tail    = ring_next(r_tail);
                            n_count   = r_count + CW'(1);
                            n_status  = fqmm_pkg::ST_OK;
                            n_cnt_out = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_out_valid = 1'b1;
                        n_status    = fqmm_pkg::ST_EMPTY;
                        n_cnt_out   = r_count;
                    end else if (op == fqmm_pkg::OP_DEQ) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_head;
                        n_head    = ring_next(r_head);
                        n_count   = r_count - CW'(1);
                        n_state   = fqmm_pkg::S_DEQ;
                    end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = r_head;
                        n_rd_ptr   = ring_next(r_head);
                        n_left     = r_count;
                        n_first    = 1'b1;
                        n_find_max = (op == fqmm_pkg::OP_MAX);
                        n_state    = fqmm_pkg::S_SCAN;
                    end
                end
            end
            fqmm_pkg::S_DEQ: begin
                n_out_valid = 1'b1;
                n_status    = fqmm_pkg::ST_OK;
                n_id        = rd_id;
                n_score     = rd_score;
                n_cnt_out   = r_count;
                n_state     = fqmm_pkg::S_IDLE;
            end
            fqmm_pkg::S_SCAN: begin
                best_ctl.en       = 1'b1;
                best_ctl.first    = r_first;
                best_ctl.find_max = r_find_max;
                n_first           = 1'b0;
                n_left            = r_left - CW'(1);
                if (r_left > CW'(1)) begin
                    ram_re   = 1'b1;
                    n_rd_ptr = ring_next(r_rd_ptr);
                end else begin
                    n_state = fqmm_pkg::S_FIN;
                end
            end
            fqmm_pkg::S_FIN: begin
                n_out_valid = 1'b1;
                n_status    = fqmm_pkg::ST_OK;
                n_id        = best_id;
                n_score     = best_score;
                n_cnt_out   = r_count;
                n_state     = fqmm_pkg::S_IDLE;
            end
            default: begin
                n_state = fqmm_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_id    = r_id;
    assign o_found_score = r_score;
    assign o_entry_count = r_cnt_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above depth");

    a_scan_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fqmm_pkg::S_SCAN) |-> (r_left != '0))
        else $error("scan running with no entries left");

    a_deq_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fqmm_pkg::S_DEQ) |=> (r_out_valid && r_status == fqmm_pkg::ST_OK))
        else $error("dequeue did not produce a result");

    a_fin_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fqmm_pkg::S_FIN) |=> (r_out_valid && r_cnt_out == r_count))
        else $error("search result missing or count mismatch");

    a_enq_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && op == fqmm_pkg::OP_ENQ && r_count == '0) |=> (r_count == CW'(1)))
        else $error("enqueue into empty queue did not store");

endmodule
